// ----- src/rsth_pkg.sv -----
// Shared constants, codes and elaboration-time helpers for the rise/set
// transit and half-arc pipeline. No dependencies.
package rsth_pkg;

    // Fixed-point constants (Q60 radians, Q30 day fractions)
    localparam logic signed [63:0] PI_Q60       = 64'sh3243_F6A8_885A_308D;
    localparam logic signed [63:0] TWO_PI_Q60   = PI_Q60 <<< 1;
    localparam logic signed [63:0] HALF_PI_Q60  = PI_Q60 >>> 1;
    localparam logic signed [63:0] GAIN_INV_Q60 = 64'sd700114967507363238;
    localparam logic [31:0]        TWO_OVER_PI_Q32   = 32'd2734261102;
    localparam logic [30:0]        SIDEREAL_RATE_Q30 = 31'd1070810509;
    localparam logic signed [63:0] ARCMIN_Q60   = PI_Q60 / 10800;
    localparam logic [24:0]        ARCMIN_LO    = ARCMIN_Q60[24:0];
    localparam logic [23:0]        ARCMIN_HI    = ARCMIN_Q60[48:25];
    localparam logic [30:0]        ONE_Q30      = 31'h4000_0000;
    localparam logic [29:0]        HALF_Q30     = 30'h2000_0000;
    localparam logic [29:0]        QUARTER_Q30  = 30'h1000_0000;

    // Pipeline step counts of the divider and the square root
    localparam int DIV_STEPS  = 31;
    localparam int SQRT_STEPS = 32;

    // Twilight kinds
    localparam logic [2:0] KIND_NORMAL = 3'd0;
    localparam logic [2:0] KIND_96     = 3'd1;
    localparam logic [2:0] KIND_102    = 3'd2;
    localparam logic [2:0] KIND_108    = 3'd3;
    localparam logic [2:0] KIND_CUSTOM = 3'd4;

    // Zenith distances in arc minutes
    localparam logic [13:0] ZEN_NORMAL_AM = 14'd5450;
    localparam logic [13:0] ZEN_96_AM     = 14'd5760;
    localparam logic [13:0] ZEN_102_AM    = 14'd6120;
    localparam logic [13:0] ZEN_108_AM    = 14'd6480;

    // Configuration register indexes
    localparam logic [1:0] CFG_LATITUDE = 2'd0;
    localparam logic [1:0] CFG_ZEN_DEG  = 2'd1;
    localparam logic [1:0] CFG_ZEN_MIN  = 2'd2;

    // v / (2k+1) for the arctangent series
    function automatic logic signed [63:0] odd_div(input logic signed [63:0] v, input int k);
        logic signed [63:0] r;
        case (k)
            0:  r = v;
            1:  r = v / 3;
            2:  r = v / 5;
            3:  r = v / 7;
            4:  r = v / 9;
            5:  r = v / 11;
            6:  r = v / 13;
            7:  r = v / 15;
            8:  r = v / 17;
            9:  r = v / 19;
            10: r = v / 21;
            11: r = v / 23;
            12: r = v / 25;
            13: r = v / 27;
            14: r = v / 29;
            15: r = v / 31;
            16: r = v / 33;
            17: r = v / 35;
            18: r = v / 37;
            19: r = v / 39;
            20: r = v / 41;
            21: r = v / 43;
            22: r = v / 45;
            23: r = v / 47;
            24: r = v / 49;
            25: r = v / 51;
            26: r = v / 53;
            27: r = v / 55;
            28: r = v / 57;
            29: r = v / 59;
            30: r = v / 61;
            default: r = v / 63;
        endcase
        return r;
    endfunction

    // atan(2^-idx) in Q60, evaluated at elaboration
    function automatic logic signed [63:0] atan_q60(input int idx);
        logic signed [63:0] sum;
        logic signed [63:0] t;
        int e;
        sum = '0;
        if (idx == 0) begin
            return PI_Q60 >>> 2;
        end
        for (int k = 0; k < 32; k++) begin
            e = 62 - idx * (2 * k + 1);
            if (e >= 0) begin
                t = odd_div(64'sd1 <<< e, k);
                sum = ((k & 1) != 0) ? sum - t : sum + t;
            end
        end
        return (sum + 64'sd2) >>> 2;
    endfunction

    // Q60 to Q30, rounded half up
    function automatic logic signed [33:0] rnd30(input logic signed [63:0] v);
        logic signed [63:0] s;
        s = (v + 64'sd536870912) >>> 30;
        return s[33:0];
    endfunction

endpackage

// ----- src/rise_set_transit_and_half_arc_top.sv -----
// Rise/set transit time and half diurnal arc, fully pipelined.
// Pipeline depth is set by the two CORDIC chains, the 31-step divider and the
// 32-step square root. Throughput: one transaction per cycle; the whole pipe
// holds while a result waits unaccepted.
// Reset (sync, active low) drops all in-flight valids and restores the registers.
// Uses rsth_pkg, rsth_fold, rsth_cordic_cell, rsth_div_cell, rsth_sqrt_cell.
module rise_set_transit_and_half_arc_top import rsth_pkg::*; #(
    parameter int CORDIC_STAGES = 28
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [95:0] i_s_tdata,   // right_ascension[30:0], declination[60:31],
                                     // sidereal_time[91:61], zero pad
    input  logic [2:0]  i_s_tuser,   // twilight_kind[2:0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // transit_time[30:0], half_arc[60:31], zero pad
    output logic        o_m_tuser,   // never_crosses
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [29:0] i_cfg_data
);

    // Stage numbers: data sitting in registers of stage k
    localparam int ST_ROT  = 5 + CORDIC_STAGES;        // rotation CORDIC out
    localparam int ST_ABS  = ST_ROT + 4;               // |num|, |den|
    localparam int ST_DIV  = ST_ABS + DIV_STEPS;       // quotient
    localparam int ST_V    = ST_DIV + 2;               // 1 - x^2
    localparam int ST_SQRT = ST_V + SQRT_STEPS;        // sqrt(1 - x^2)
    localparam int ST_VEC  = ST_SQRT + CORDIC_STAGES;  // acos angle
    localparam int ST_HP   = ST_VEC + 2;               // scaled arc product

    // Side info travelling along with each transaction
    typedef struct packed {
        logic [30:0] tr;     // transit time
        logic [2:0]  neg;    // cosine sign flip per chain
        logic        flag;   // never crosses
        logic        refl;   // reflect arc to 0.5 - h
        logic [30:0] xq;     // |x| in Q30
        logic        xq0;    // |x| is zero
    } t_side;

    // ---------------- registers and flow control ----------------
    logic signed [29:0] r_lat;
    logic [7:0]         r_zdeg;
    logic [5:0]         r_zmin;
    logic               w_en;
    logic               r_ov;
    logic [ST_HP:1]     r_vld;
    t_side              r_sd [5:ST_HP];
    t_side              n_sd [6:ST_HP];

    assign w_en        = !r_ov || i_m_tready;
    assign o_s_tready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat  <= '0;
            r_zdeg <= 8'd90;
            r_zmin <= 6'd50;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LATITUDE: r_lat  <= i_cfg_data;
                CFG_ZEN_DEG:  r_zdeg <= i_cfg_data[7:0];
                CFG_ZEN_MIN:  r_zmin <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else if (w_en) begin
            r_vld <= {r_vld[ST_HP-1:1], i_s_tvalid};
            r_ov  <= r_vld[ST_HP];
        end
    end

    // ---------------- stage 1: RA scaling, zenith select ----------------
    logic [62:0]        r1_rap;
    logic [30:0]        r1_st;
    logic signed [29:0] r1_dec, r1_lat;
    logic [13:0]        r1_am;
    logic [13:0]        n_am;

    always_comb begin
        unique case (i_s_tuser)
            KIND_96:     n_am = ZEN_96_AM;
            KIND_102:    n_am = ZEN_102_AM;
            KIND_108:    n_am = ZEN_108_AM;
            KIND_CUSTOM: n_am = 14'(r_zdeg) * 14'd60 + 14'(r_zmin);
            default:     n_am = ZEN_NORMAL_AM;   // normal and unused codes
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_rap <= 63'(i_s_tdata[30:0]) * 63'(TWO_OVER_PI_Q32);
            r1_dec <= i_s_tdata[60:31];
            r1_st  <= i_s_tdata[91:61];
            r1_lat <= r_lat;
            r1_am  <= n_am;
        end
    end

    // ---------------- stage 2: hour difference wrap, zenith partials ----------------
    logic signed [31:0] r2_d;
    logic [38:0]        r2_plo;
    logic [37:0]        r2_phi;
    logic signed [29:0] r2_dec, r2_lat;
    logic [62:0]        n_ras;
    logic signed [31:0] n_dr, n_d;

    always_comb begin
        n_ras = (r1_rap + 63'h8000_0000) >> 32;
        n_dr  = $signed({1'b0, n_ras[30:0]}) - $signed({1'b0, r1_st});
        if (n_dr > 32'sd536870912) begin
            n_d = n_dr - 32'sd1073741824;
        end else if (n_dr < -32'sd536870912) begin
            n_d = n_dr + 32'sd1073741824;
        end else begin
            n_d = n_dr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_d   <= n_d;
            r2_plo <= 39'(r1_am) * 39'(ARCMIN_LO);
            r2_phi <= 38'(r1_am) * 38'(ARCMIN_HI);
            r2_dec <= r1_dec;
            r2_lat <= r1_lat;
        end
    end

    // ---------------- stage 3: sidereal rate product, Q60 angles ----------------
    logic signed [63:0] r3_ttp, r3_za, r3_la, r3_da;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_ttp <= 64'(r2_d) * $signed({33'd0, SIDEREAL_RATE_Q30});
            r3_za  <= $signed({1'b0, r2_phi, 25'd0}) + $signed({25'd0, r2_plo});
            r3_la  <= {{2{r2_lat[29]}}, r2_lat, 32'd0};
            r3_da  <= {{2{r2_dec[29]}}, r2_dec, 32'd0};
        end
    end

    // ---------------- stage 4: transit time ----------------
    logic [30:0]        r4_tr;
    logic signed [63:0] n_ttr;
    logic [29:0]        n_tt;

    always_comb begin
        n_ttr = (r3_ttp + 64'sd536870912) >>> 30;
        n_tt  = n_ttr[29:0] + HALF_Q30;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_tr <= (n_tt == '0) ? ONE_Q30 : {1'b0, n_tt};
        end
    end

    // ---------------- stages 4..5+N: sine/cosine of zenith, latitude, declination ----------------
    logic signed [63:0] w_fin [3];
    logic signed [63:0] w_fa  [3];
    logic               w_fn  [3];
    logic signed [63:0] w_rx  [3][CORDIC_STAGES+1];
    logic signed [63:0] w_ry  [3][CORDIC_STAGES+1];
    logic signed [63:0] w_rz  [3][CORDIC_STAGES+1];

    assign w_fin[0] = r3_za;
    assign w_fin[1] = r3_la;
    assign w_fin[2] = r3_da;

    for (genvar c = 0; c < 3; c++) begin : g_rot
        rsth_fold u_fold (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_ang (w_fin[c]),
            .o_ang (w_fa[c]),
            .o_neg (w_fn[c])
        );
        assign w_rx[c][0] = GAIN_INV_Q60;
        assign w_ry[c][0] = '0;
        assign w_rz[c][0] = w_fa[c];
        for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cell
            rsth_cordic_cell #(.IDX(j), .VEC(1'b0)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_x   (w_rx[c][j]),
                .i_y   (w_ry[c][j]),
                .i_z   (w_rz[c][j]),
                .o_x   (w_rx[c][j+1]),
                .o_y   (w_ry[c][j+1]),
                .o_z   (w_rz[c][j+1])
            );
        end
    end

    // ---------------- ST_ROT+1 .. ST_ABS: numerator and denominator ----------------
    logic signed [33:0] r_cos [3];
    logic signed [33:0] r_sin [3];
    logic signed [33:0] r_cz;
    logic signed [63:0] r_spsd, r_cpcd, r_num, r_den;
    logic [63:0]        r_an, r_ad;
    logic               r_refl;
    logic               n_flag;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_cos[c] <= r_sd[ST_ROT].neg[c] ? -rnd30(w_rx[c][CORDIC_STAGES])
                                                 :  rnd30(w_rx[c][CORDIC_STAGES]);
                r_sin[c] <= rnd30(w_ry[c][CORDIC_STAGES]);
            end
            r_cz   <= r_cos[0];
            r_spsd <= 64'(r_sin[1]) * 64'(r_sin[2]);
            r_cpcd <= 64'(r_cos[1]) * 64'(r_cos[2]);
            r_num  <= (64'(r_cz) <<< 30) - r_spsd;
            r_den  <= r_cpcd;
            r_an   <= r_num[63] ? 64'(-r_num) : 64'(r_num);
            r_ad   <= r_den[63] ? 64'(-r_den) : 64'(r_den);
            r_refl <= (r_num != '0) && (r_num[63] != r_den[63]);
        end
    end

    // |cos| beyond one, or a pole: no crossing
    assign n_flag = (r_ad == '0) || (r_an > r_ad);

    // ---------------- ST_ABS+1 .. ST_DIV: |x| = |num| / |den| in Q30 ----------------
    logic [63:0] w_dr [DIV_STEPS+1];
    logic [63:0] w_dd [DIV_STEPS+1];
    logic [30:0] w_dq [DIV_STEPS+1];

    assign w_dr[0] = r_an;
    assign w_dd[0] = r_ad;
    assign w_dq[0] = '0;

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        rsth_div_cell #(.FIRST(j == 0)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_r   (w_dr[j]),
            .i_d   (w_dd[j]),
            .i_q   (w_dq[j]),
            .o_r   (w_dr[j+1]),
            .o_d   (w_dd[j+1]),
            .o_q   (w_dq[j+1])
        );
    end

    // ---------------- ST_DIV+1 .. ST_SQRT: sqrt(1 - x^2) ----------------
    logic [61:0] r_sq;
    logic [63:0] r_v;
    logic [63:0] w_sv [SQRT_STEPS+1];
    logic [63:0] w_sr [SQRT_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq <= 62'(w_dq[DIV_STEPS]) * 62'(w_dq[DIV_STEPS]);
            r_v  <= 64'h1000_0000_0000_0000 - 64'(r_sq);
        end
    end

    assign w_sv[0] = r_v;
    assign w_sr[0] = '0;

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        rsth_sqrt_cell #(.IDX(j)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_v   (w_sv[j]),
            .i_res (w_sr[j]),
            .o_v   (w_sv[j+1]),
            .o_res (w_sr[j+1])
        );
    end

    // ---------------- ST_SQRT+1 .. ST_VEC: acos via atan2(sqrt(1-x^2), x) ----------------
    logic signed [63:0] w_vx [CORDIC_STAGES+1];
    logic signed [63:0] w_vy [CORDIC_STAGES+1];
    logic signed [63:0] w_vz [CORDIC_STAGES+1];

    assign w_vx[0] = $signed({3'd0, r_sd[ST_SQRT].xq, 30'd0});
    assign w_vy[0] = $signed({3'd0, w_sr[SQRT_STEPS][30:0], 30'd0});
    assign w_vz[0] = '0;

    for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_vec
        rsth_cordic_cell #(.IDX(j), .VEC(1'b1)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (w_vx[j]),
            .i_y   (w_vy[j]),
            .i_z   (w_vz[j]),
            .o_x   (w_vx[j+1]),
            .o_y   (w_vy[j+1]),
            .o_z   (w_vz[j+1])
        );
    end

    // ---------------- ST_VEC+1 .. ST_HP: angle to day fraction ----------------
    logic [30:0]        r_ang;
    logic [62:0]        r_hp;
    logic signed [33:0] n_ang;

    assign n_ang = rnd30(w_vz[CORDIC_STAGES]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ang <= n_ang[33] ? '0 : n_ang[30:0];   // CORDIC undershoot clamps to 0
            r_hp  <= 63'(r_ang) * 63'(TWO_OVER_PI_Q32);
        end
    end

    // ---------------- side info line ----------------
    always_comb begin
        for (int k = 6; k <= ST_HP; k++) begin
            n_sd[k] = r_sd[k-1];
            if (k == 6) begin
                n_sd[k].neg = {w_fn[2], w_fn[1], w_fn[0]};
            end
            if (k == ST_ABS + 1) begin
                n_sd[k].flag = n_flag;
                n_sd[k].refl = r_refl;
            end
            if (k == ST_DIV + 1) begin
                n_sd[k].xq  = w_dq[DIV_STEPS];
                n_sd[k].xq0 = (w_dq[DIV_STEPS] == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[5] <= '{tr: r4_tr, default: '0};
            for (int k = 6; k <= ST_HP; k++) begin
                r_sd[k] <= n_sd[k];
            end
        end
    end

    // ---------------- output register ----------------
    logic [62:0] n_hs;
    logic [29:0] n_h;
    logic [30:0] r_otr;
    logic [29:0] r_oh;
    logic        r_ofl;

    always_comb begin
        n_hs = (r_hp + 63'h2_0000_0000) >> 34;
        n_h  = n_hs[29:0];
        if (n_h > QUARTER_Q30) begin
            n_h = QUARTER_Q30;
        end
        if (r_sd[ST_HP].xq0) begin
            n_h = QUARTER_Q30;                 // x of zero: a quarter day
        end
        if (r_sd[ST_HP].refl) begin
            n_h = HALF_Q30 - n_h;              // negative x: other side of the meridian
        end
        if (r_sd[ST_HP].flag) begin
            n_h = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_otr <= r_sd[ST_HP].tr;
            r_oh  <= n_h;
            r_ofl <= r_sd[ST_HP].flag;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {3'd0, r_oh, r_otr};
    assign o_m_tuser  = r_ofl;

endmodule

// ----- src/rsth_fold.sv -----
// Two-stage angle reduction ahead of a rotation CORDIC chain: wrap into
// [-pi, pi], then fold into [-pi/2, pi/2] with a cosine sign flag. Uses rsth_pkg.
module rsth_fold import rsth_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_ang,
    output logic signed [63:0] o_ang,
    output logic               o_neg
);

    logic signed [63:0] r_w;
    logic signed [63:0] r_a;
    logic               r_neg;
    logic signed [63:0] n_w;

    always_comb begin
        if (i_ang > PI_Q60) begin
            n_w = i_ang - TWO_PI_Q60;
        end else if (i_ang < -PI_Q60) begin
            n_w = i_ang + TWO_PI_Q60;
        end else begin
            n_w = i_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w <= n_w;
            if (r_w > HALF_PI_Q60) begin
                r_a   <= PI_Q60 - r_w;
                r_neg <= 1'b1;
            end else if (r_w < -HALF_PI_Q60) begin
                r_a   <= -PI_Q60 - r_w;
                r_neg <= 1'b1;
            end else begin
                r_a   <= r_w;
                r_neg <= 1'b0;
            end
        end
    end

    assign o_ang = r_a;
    assign o_neg = r_neg;

endmodule

// ----- src/rsth_cordic_cell.sv -----
// One registered CORDIC micro-rotation, rotation or vectoring mode.
// Uses rsth_pkg for the arctangent constant.
module rsth_cordic_cell import rsth_pkg::*; #(
    parameter int IDX = 0,
    parameter bit VEC = 1'b0
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_x,
    input  logic signed [63:0] i_y,
    input  logic signed [63:0] i_z,
    output logic signed [63:0] o_x,
    output logic signed [63:0] o_y,
    output logic signed [63:0] o_z
);

    localparam logic signed [63:0] ATAN = atan_q60(IDX);

    logic signed [63:0] r_x, r_y, r_z;
    logic signed [63:0] n_dx, n_dy;
    logic               n_ccw;

    always_comb begin
        n_ccw = VEC ? (i_y <= 64'sd0) : (i_z >= 64'sd0);
        n_dx  = i_x >>> IDX;
        n_dy  = i_y >>> IDX;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_ccw) begin
                r_x <= i_x - n_dy;
                r_y <= i_y + n_dx;
                r_z <= i_z - ATAN;
            end else begin
                r_x <= i_x + n_dy;
                r_y <= i_y - n_dx;
                r_z <= i_z + ATAN;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ----- src/rsth_div_cell.sv -----
// One registered restoring-division step producing one quotient bit.
// Uses rsth_pkg.
module rsth_div_cell import rsth_pkg::*; #(
    parameter bit FIRST = 1'b0
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_r,
    input  logic [63:0] i_d,
    input  logic [30:0] i_q,
    output logic [63:0] o_r,
    output logic [63:0] o_d,
    output logic [30:0] o_q
);

    logic [63:0] r_r, r_d;
    logic [30:0] r_q;
    logic [63:0] n_rs;
    logic        n_ge;

    always_comb begin
        n_rs = FIRST ? i_r : (i_r << 1);
        n_ge = (n_rs >= i_d);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r <= n_ge ? (n_rs - i_d) : n_rs;
            r_d <= i_d;
            r_q <= {i_q[29:0], n_ge};
        end
    end

    assign o_r = r_r;
    assign o_d = r_d;
    assign o_q = r_q;

endmodule

// ----- src/rsth_sqrt_cell.sv -----
// One registered step of the digit-by-digit integer square root.
// Uses rsth_pkg.
module rsth_sqrt_cell import rsth_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_v,
    input  logic [63:0] i_res,
    output logic [63:0] o_v,
    output logic [63:0] o_res
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * IDX);

    logic [63:0] r_v, r_res;
    logic [63:0] n_try;

    assign n_try = i_res + BIT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_v >= n_try) begin
                r_v   <= i_v - n_try;
                r_res <= (i_res >> 1) + BIT;
            end else begin
                r_v   <= i_v;
                r_res <= i_res >> 1;
            end
        end
    end

    assign o_v   = r_v;
    assign o_res = r_res;

endmodule
